>>> rtl/core/rbsi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_pkg: shared constants for the ray/box slab intersect block
// Axis count, divider stepping and threshold register format.
// ----------------------------------------------------------------------------
package rbsi_pkg;

	localparam int unsigned N_AXES     = 3;
	localparam int unsigned DIV_STEPS  = 4;  // quotient bits per divider stage
	localparam int unsigned THRESH_W   = 16;
	localparam logic [THRESH_W-1:0] THRESH_RST = 16'd1;

	function automatic int unsigned div_stages(input int unsigned nw);
		return (nw + DIV_STEPS - 1) / DIV_STEPS;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/ray_box_slab_intersect_top.sv
// Path: an input beat passes stage 1, the divider stages, stages 2 to 4 and the output buffer (Q16.16 by default).
// Throughput: one ray/box pair per cycle while s_tready is high; the divider pipeline sets the depth.
// A two-beat output buffer keeps s_tready high while one result waits.
// Reset: arst_n clears all valid state and sets the threshold to 1.
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top: ray versus axis-aligned box slab test
// Pipelined per-axis slab division, fold of entry/exit and entry point.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_top
	import rbsi_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [THRESH_W-1:0]                   cfg_wr_data,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// origin_x/y/z, dir_x/y/z, box_low_x/y/z, box_high_x/y/z, zero pad
	input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// hit, entry_param, entry_x, entry_y, entry_z, zero pad
	output logic      [((4*COORD_WIDTH+7)/8)*8-1:0]    m_tdata
);

	localparam int unsigned CW  = COORD_WIDTH;
	localparam int unsigned FB  = FRAC_BITS;
	localparam int unsigned OW  = ((4*CW+7)/8)*8;
	localparam int unsigned NW  = CW + 1 + FB;
	localparam int unsigned NS  = div_stages(NW);
	localparam int unsigned PW  = 2*CW - 1;
	localparam int unsigned XW  = (PW > CW + 2) ? PW : CW + 2;
	localparam int unsigned AXW = 2*CW + 3;
	localparam int unsigned SBW = 2 + N_AXES*AXW;

	localparam logic [NW-1:0]        QSIGN = NW'(1) << (CW-1);
	localparam logic [NW-1:0]        QMAX  = QSIGN - NW'(1);
	localparam logic signed [CW-1:0] CMAX  = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN  = {1'b1, {(CW-1){1'b0}}};
	localparam logic [XW-1:0]        CAP   = XW'(1) << CW;

	logic [THRESH_W-1:0] thresh_q;
	logic                en;
	logic [1:0]          cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RST;
		end else if (cfg_wr_en) begin
			thresh_q <= cfg_wr_data;
		end
	end

	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;

	// stage 1: differences, magnitudes, parallel test
	logic signed [CW-1:0] o_in [N_AXES];
	logic signed [CW-1:0] d_in [N_AXES];
	logic signed [CW-1:0] lo_in [N_AXES];
	logic signed [CW-1:0] hi_in [N_AXES];
	logic signed [CW:0]   dl_c [N_AXES];
	logic signed [CW:0]   dh_c [N_AXES];
	logic [N_AXES-1:0]    par_c;
	logic [N_AXES-1:0]    out_c;

	always_comb begin
		for (int a = 0; a < N_AXES; a++) begin
			o_in[a]  = s_tdata[a*CW +: CW];
			d_in[a]  = s_tdata[(3+a)*CW +: CW];
			lo_in[a] = s_tdata[(6+a)*CW +: CW];
			hi_in[a] = s_tdata[(9+a)*CW +: CW];
			dl_c[a]  = {lo_in[a][CW-1], lo_in[a]} - {o_in[a][CW-1], o_in[a]};
			dh_c[a]  = {hi_in[a][CW-1], hi_in[a]} - {o_in[a][CW-1], o_in[a]};
			par_c[a] = (d_in[a] == '0) ||
				((d_in[a][CW-1] ? -d_in[a] : d_in[a]) < CW'(thresh_q));
			out_c[a] = (o_in[a] < lo_in[a]) || (o_in[a] > hi_in[a]);
		end
	end

	logic                 valid_s1;
	logic [CW:0]          nl_s1 [N_AXES];
	logic [CW:0]          nh_s1 [N_AXES];
	logic [CW-1:0]        dm_s1 [N_AXES];
	logic signed [CW-1:0] o_s1 [N_AXES];
	logic signed [CW-1:0] d_s1 [N_AXES];
	logic [N_AXES-1:0]    par_s1;
	logic [N_AXES-1:0]    negl_s1;
	logic [N_AXES-1:0]    negh_s1;
	logic                 pmiss_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < N_AXES; a++) begin
				nl_s1[a]   <= dl_c[a][CW] ? -dl_c[a] : dl_c[a];
				nh_s1[a]   <= dh_c[a][CW] ? -dh_c[a] : dh_c[a];
				dm_s1[a]   <= d_in[a][CW-1] ? -d_in[a] : d_in[a];
				o_s1[a]    <= o_in[a];
				d_s1[a]    <= d_in[a];
				negl_s1[a] <= dl_c[a][CW] ^ d_in[a][CW-1];
				negh_s1[a] <= dh_c[a][CW] ^ d_in[a][CW-1];
			end
			par_s1   <= par_c;
			pmiss_s1 <= |(par_c & out_c);
		end
	end

	// slab dividers
	logic [NW-1:0] ql_d [N_AXES];
	logic [NW-1:0] qh_d [N_AXES];

	for (genvar a = 0; a < N_AXES; a++) begin : g_axis
		rbsi_div #(.NW(NW), .DW(CW)) u_div_lo (
			.clk (clk),
			.en  (en),
			.num ({nl_s1[a], {FB{1'b0}}}),
			.den (dm_s1[a]),
			.quo (ql_d[a])
		);
		rbsi_div #(.NW(NW), .DW(CW)) u_div_hi (
			.clk (clk),
			.en  (en),
			.num ({nh_s1[a], {FB{1'b0}}}),
			.den (dm_s1[a]),
			.quo (qh_d[a])
		);
	end

	logic [SBW-1:0] sb_in;
	logic [SBW-1:0] sb_out;

	always_comb begin
		sb_in[0] = valid_s1;
		sb_in[1] = pmiss_s1;
		for (int a = 0; a < N_AXES; a++) begin
			sb_in[2 + a*AXW +: AXW] = {negh_s1[a], negl_s1[a], par_s1[a], d_s1[a], o_s1[a]};
		end
	end

	rbsi_delay #(.W(SBW), .D(NS)) u_side (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (sb_in),
		.dout   (sb_out)
	);

	// stage 2: sign, saturate and order slab parameters
	logic signed [CW-1:0] tl_c [N_AXES];
	logic signed [CW-1:0] th_c [N_AXES];

	always_comb begin
		for (int a = 0; a < N_AXES; a++) begin
			if (sb_out[2 + a*AXW + 2*CW + 1]) begin
				tl_c[a] = (ql_d[a] > QSIGN) ? CMIN : -$signed(ql_d[a][CW-1:0]);
			end else begin
				tl_c[a] = (ql_d[a] > QMAX) ? CMAX : $signed(ql_d[a][CW-1:0]);
			end
			if (sb_out[2 + a*AXW + 2*CW + 2]) begin
				th_c[a] = (qh_d[a] > QSIGN) ? CMIN : -$signed(qh_d[a][CW-1:0]);
			end else begin
				th_c[a] = (qh_d[a] > QMAX) ? CMAX : $signed(qh_d[a][CW-1:0]);
			end
		end
	end

	logic                 valid_s2;
	logic                 pmiss_s2;
	logic signed [CW-1:0] t1_s2 [N_AXES];
	logic signed [CW-1:0] t2_s2 [N_AXES];
	logic [N_AXES-1:0]    par_s2;
	logic signed [CW-1:0] o_s2 [N_AXES];
	logic signed [CW-1:0] d_s2 [N_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= sb_out[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pmiss_s2 <= sb_out[1];
			for (int a = 0; a < N_AXES; a++) begin
				t1_s2[a]  <= (tl_c[a] > th_c[a]) ? th_c[a] : tl_c[a];
				t2_s2[a]  <= (tl_c[a] > th_c[a]) ? tl_c[a] : th_c[a];
				o_s2[a]   <= sb_out[2 + a*AXW +: CW];
				d_s2[a]   <= sb_out[2 + a*AXW + CW +: CW];
				par_s2[a] <= sb_out[2 + a*AXW + 2*CW];
			end
		end
	end

	// stage 3: fold entry and exit over the axes
	logic signed [CW-1:0] tmin_c;
	logic signed [CW-1:0] tmax_c;
	logic                 hit_c;

	always_comb begin
		tmin_c = '0;
		tmax_c = CMAX;
		for (int a = 0; a < N_AXES; a++) begin
			if (!par_s2[a]) begin
				if (t1_s2[a] > tmin_c) tmin_c = t1_s2[a];
				if (t2_s2[a] < tmax_c) tmax_c = t2_s2[a];
			end
		end
		hit_c = !pmiss_s2 && (tmin_c <= tmax_c);
	end

	logic                 valid_s3;
	logic                 hit_s3;
	logic [CW-2:0]        tmin_s3;
	logic [CW-1:0]        dm_s3 [N_AXES];
	logic [N_AXES-1:0]    dneg_s3;
	logic signed [CW-1:0] o_s3 [N_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3  <= hit_c;
			tmin_s3 <= hit_c ? tmin_c[CW-2:0] : '0;
			for (int a = 0; a < N_AXES; a++) begin
				dm_s3[a]   <= d_s2[a][CW-1] ? -d_s2[a] : d_s2[a];
				dneg_s3[a] <= d_s2[a][CW-1];
				o_s3[a]    <= o_s2[a];
			end
		end
	end

	// stage 4: |dir| * tmin
	logic                 valid_s4;
	logic                 hit_s4;
	logic [CW-2:0]        tmin_s4;
	logic [PW-1:0]        prod_s4 [N_AXES];
	logic [N_AXES-1:0]    dneg_s4;
	logic signed [CW-1:0] o_s4 [N_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4  <= hit_s3;
			tmin_s4 <= tmin_s3;
			dneg_s4 <= dneg_s3;
			for (int a = 0; a < N_AXES; a++) begin
				prod_s4[a] <= PW'(dm_s3[a]) * PW'(tmin_s3);
				o_s4[a]    <= o_s3[a];
			end
		end
	end

	// entry point, saturated; zero on a miss
	logic [XW-1:0]        sh_c [N_AXES];
	logic [CW:0]          m_c  [N_AXES];
	logic signed [CW+1:0] sum_c [N_AXES];
	logic signed [CW-1:0] ent_c [N_AXES];
	logic [OW-1:0]        res_c;

	always_comb begin
		for (int a = 0; a < N_AXES; a++) begin
			sh_c[a] = XW'(prod_s4[a]) >> FB;
			m_c[a]  = (sh_c[a] > CAP) ? CAP[CW:0] : sh_c[a][CW:0];
			sum_c[a] = {{2{o_s4[a][CW-1]}}, o_s4[a]} +
				(dneg_s4[a] ? -$signed({1'b0, m_c[a]}) : $signed({1'b0, m_c[a]}));
			if (!hit_s4) begin
				ent_c[a] = '0;
			end else if (sum_c[a] > (CW+2)'(CMAX)) begin
				ent_c[a] = CMAX;
			end else if (sum_c[a] < (CW+2)'(CMIN)) begin
				ent_c[a] = CMIN;
			end else begin
				ent_c[a] = sum_c[a][CW-1:0];
			end
		end
		res_c = OW'({ent_c[2], ent_c[1], ent_c[0], tmin_s4, hit_s4});
	end

	// two-beat output buffer
	logic [OW-1:0] buf_q [2];
	logic          wp_q;
	logic          rp_q;
	logic          push;
	logic          pop;

	assign push = valid_s4 && en;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= res_c;
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = buf_q[rp_q];

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[4*CW-1:1] == '0))
		else $error("miss beat carries non-zero entry data");

	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire

>>> rtl/core/rbsi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_div: pipelined unsigned restoring divider
// Up to DIV_STEPS quotient bits per stage; quotient replaces dividend bit by bit.
// ----------------------------------------------------------------------------
module rbsi_div
	import rbsi_pkg::*;
#(
	parameter int unsigned NW = 49,
	parameter int unsigned DW = 32
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [NW-1:0] quo
);

	localparam int unsigned NS = div_stages(NW);

	logic [NW-1:0] nq_q  [NS];
	logic [DW-1:0] rem_q [NS];
	logic [DW-1:0] den_q [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [NW-1:0] nq_in;
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [NW-1:0] nq_c;
		logic [DW-1:0] rem_c;

		if (g == 0) begin : g_first
			assign nq_in  = num;
			assign rem_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign nq_in  = nq_q[g-1];
			assign rem_in = rem_q[g-1];
			assign den_in = den_q[g-1];
		end

		always_comb begin
			logic [DW:0] r;
			nq_c  = nq_in;
			rem_c = rem_in;
			for (int k = 0; k < DIV_STEPS; k++) begin
				if (g * DIV_STEPS + k < NW) begin
					r    = {rem_c, nq_c[NW-1]};
					nq_c = {nq_c[NW-2:0], 1'b0};
					if (r >= {1'b0, den_in}) begin
						r       = r - {1'b0, den_in};
						nq_c[0] = 1'b1;
					end
					rem_c = r[DW-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_q[g]  <= nq_c;
				rem_q[g] <= rem_c;
				den_q[g] <= den_in;
			end
		end
	end

	assign quo = nq_q[NS-1];

endmodule

`default_nettype wire

>>> rtl/core/rbsi_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_delay: stallable delay line
// Carries valid and side data alongside the divider stages.
// ----------------------------------------------------------------------------
module rbsi_delay
	import rbsi_pkg::*;
#(
	parameter int unsigned W = 8,
	parameter int unsigned D = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [W-1:0] din,
	output logic      [W-1:0] dout
);

	logic [W-1:0] tap_q [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) tap_q[i] <= '0;
		end else if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < D; i++) tap_q[i] <= tap_q[i-1];
		end
	end

	assign dout = tap_q[D-1];

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for ray_box_slab_intersect_top
// Drives ray/box beats with random gaps and back-pressure, predicts each
// result with a local fixed-point slab model or a fixed row, and compares field by field.
// The threshold register is rewritten between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rbsi_pkg::*;

	localparam longint CMAX = 64'sd2147483647;
	localparam longint CMIN = -64'sd2147483648;
	localparam longint unsigned CSIGN = 64'd2147483648;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_PER_PHASE = 280;

	typedef struct packed {
		logic [383:0] ray;
		bit           typed;
		logic [127:0] res;
	} ray_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic [15:0]  cfg_wr_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [383:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;

	logic [127:0] hit_q[$];
	logic [15:0]  thresh = THRESH_RST;
	int           errors = 0;
	int           cycles = 0;
	bit           idle_on = 1'b1;
	ray_row_t     rows[$];

	always #1 clk = ~clk;

	ray_box_slab_intersect_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	function automatic longint slab_quot(input longint num, input longint den);
		longint unsigned un, ud, q;
		bit neg;
		un = num < 0 ? longint'(-num) : longint'(num);
		ud = den < 0 ? longint'(-den) : longint'(den);
		neg = (num < 0) != (den < 0);
		q = (un << 16) / ud;
		if (neg) begin
			if (q >= CSIGN) return CMIN;
			return -longint'(q);
		end
		if (q > longint'(CMAX)) return CMAX;
		return longint'(q);
	endfunction

	function automatic logic [127:0] slab_result(input logic [383:0] ray,
			input logic [15:0] thr);
		longint p[3], d[3], lo[3], hi[3];
		longint tmin, tmax, t1, t2, s, prod, e;
		longint unsigned m, ad;
		bit hit;
		logic [127:0] r;
		for (int i = 0; i < 3; i++) begin
			p[i] = longint'($signed(ray[32*i +: 32]));
			d[i] = longint'($signed(ray[32*(3+i) +: 32]));
			lo[i] = longint'($signed(ray[32*(6+i) +: 32]));
			hi[i] = longint'($signed(ray[32*(9+i) +: 32]));
		end
		tmin = 0;
		tmax = CMAX;
		hit = 1'b1;
		for (int i = 0; i < 3 && hit; i++) begin
			ad = d[i] < 0 ? longint'(-d[i]) : longint'(d[i]);
			if (d[i] == 0 || ad < longint'(thr)) begin
				if (p[i] < lo[i] || p[i] > hi[i]) hit = 1'b0;
			end else begin
				t1 = slab_quot(lo[i] - p[i], d[i]);
				t2 = slab_quot(hi[i] - p[i], d[i]);
				if (t1 > t2) begin
					s = t1; t1 = t2; t2 = s;
				end
				if (t1 > tmin) tmin = t1;
				if (t2 < tmax) tmax = t2;
				if (tmin > tmax) hit = 1'b0;
			end
		end
		r = '0;
		if (!hit) return r;
		r[0] = 1'b1;
		r[31:1] = tmin[30:0];
		for (int i = 0; i < 3; i++) begin
			ad = d[i] < 0 ? longint'(-d[i]) : longint'(d[i]);
			m = (ad * longint'(tmin)) >> 16;
			if (m > 64'h1_0000_0000) m = 64'h1_0000_0000;
			prod = d[i] < 0 ? -longint'(m) : longint'(m);
			e = p[i] + prod;
			if (e > CMAX) e = CMAX;
			if (e < CMIN) e = CMIN;
			r[32*(i+1) +: 32] = e[31:0];
		end
		return r;
	endfunction

	// fields in order ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz
	function automatic logic [383:0] pack_ray(input logic [31:0] f[12]);
		logic [383:0] v;
		for (int i = 0; i < 12; i++) v[32*i +: 32] = f[i];
		return v;
	endfunction

	function automatic logic [383:0] random_ray();
		logic [31:0] f[12];
		int c, half, o, lo, hi, sel;
		if ($urandom_range(0, 9) < 2) begin
			for (int i = 0; i < 12; i++) f[i] = $urandom;
			return pack_ray(f);
		end
		for (int i = 0; i < 3; i++) begin
			c = int'($urandom_range(0, 32'h40_0000)) - 32'sh20_0000;
			half = $urandom_range(0, 32'h4_0000);
			o = int'($urandom_range(0, 32'h40_0000)) - 32'sh20_0000;
			lo = c - half;
			hi = c + half;
			if ($urandom_range(0, 19) == 0) begin
				f[6+i] = hi; f[9+i] = lo;
			end else begin
				f[6+i] = lo; f[9+i] = hi;
			end
			if ($urandom_range(0, 29) == 0) o = lo;
			f[i] = o;
			sel = $urandom_range(0, 9);
			case (sel)
				0: f[3+i] = 32'd0;
				1: f[3+i] = int'($urandom_range(0, 32'h2_0000)) - 32'sh1_0000;
				2: f[3+i] = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
				default: begin
					f[3+i] = ((c - o) >>> $urandom_range(0, 3))
						+ int'($urandom_range(0, 255)) - 128;
				end
			endcase
		end
		return pack_ray(f);
	endfunction

	task automatic add_row(input logic [31:0] f[12], input bit typed,
			input logic [127:0] res);
		ray_row_t r;
		r.ray = pack_ray(f);
		r.typed = typed;
		r.res = res;
		rows.push_back(r);
	endtask

	task automatic send_ray(input logic [383:0] ray, input bit typed,
			input logic [127:0] res);
		int gap;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ray;
		do @(posedge clk); while (!s_tready);
		hit_q.push_back(typed ? res : slab_result(ray, thresh));
	endtask

	task automatic drain_and_write(input logic [15:0] value);
		s_tvalid <= 1'b0;
		while (hit_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		thresh = value;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
		end
	endtask

	// result side
	initial begin
		int gap;
		logic [127:0] want;
		@(posedge arst_n);
		forever begin
			gap = idle_on ? $urandom_range(0, 11) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (hit_q.size() == 0) begin
				errors++;
				$display("%0t unexpected beat expected none actual %h", $time, m_tdata);
			end else begin
				want = hit_q.pop_front();
				check_field("hit", {31'd0, want[0]}, {31'd0, m_tdata[0]});
				check_field("entry_param", {1'b0, want[31:1]}, {1'b0, m_tdata[31:1]});
				check_field("entry_x", want[63:32], m_tdata[63:32]);
				check_field("entry_y", want[95:64], m_tdata[95:64]);
				check_field("entry_z", want[127:96], m_tdata[127:96]);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [15:0] phase_thr[4];
		phase_thr = '{16'd0, 16'hffff, 16'h4000, 16'd0};
		phase_thr[3] = $urandom_range(1, 16'hfffe);
		add_row('{0, 0, 0, 32'h1_0000, 0, 0, 32'h2_0000, -32'sh1_0000, -32'sh1_0000,
			32'h3_0000, 32'h1_0000, 32'h1_0000}, 1'b1,
			{32'd0, 32'd0, 32'h2_0000, 31'h2_0000, 1'b1});
		add_row('{32'h1_0000, 32'h2_0000, 32'h3_0000, 0, 0, 0,
			-32'sh10_0000, -32'sh10_0000, -32'sh10_0000,
			32'h10_0000, 32'h10_0000, 32'h10_0000}, 1'b1,
			{32'h3_0000, 32'h2_0000, 32'h1_0000, 31'd0, 1'b1});
		add_row('{32'h20_0000, 0, 0, 0, 0, 0, -32'sh1_0000, -32'sh1_0000,
			-32'sh1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000}, 1'b1, 128'd0);
		add_row('{-32'sh1_0000, 32'h1_0000, 0, 0, 0, 0, -32'sh1_0000, -32'sh1_0000,
			-32'sh1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000}, 1'b1,
			{32'd0, 32'h1_0000, 32'hffff_0000, 31'd0, 1'b1});
		add_row('{0, 0, 0, 0, 0, 0, 32'h1_0000, 0, 0, -32'sh1_0000,
			32'h1_0000, 32'h1_0000}, 1'b1, 128'd0);
		add_row('{0, 0, 0, 32'h1_0000, 0, 0, 32'h3_0000, -32'sh1_0000, -32'sh1_0000,
			32'h2_0000, 32'h1_0000, 32'h1_0000}, 1'b0, '0);
		add_row('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b0, '0);
		add_row('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b0, '0);
		add_row('{0, 0, 0, 1, 32'hffff_ffff, 1, -32'sh1_0000, -32'sh1_0000,
			-32'sh1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000}, 1'b0, '0);
		add_row('{32'h5_0000, 0, 0, -32'sh1_0000, 0, 0, 32'h1_0000, -32'sh1_0000,
			-32'sh1_0000, 32'h2_0000, 32'h1_0000, 32'h1_0000}, 1'b0, '0);
		add_row('{0, 0, 0, 32'h1_0000, 32'h1_0000, 0, 32'h1_0000, 32'h2_0000,
			-32'sh1_0000, 32'h2_0000, 32'h3_0000, 32'h1_0000}, 1'b0, '0);
		add_row('{32'h8000_0000, 0, 0, 1, 0, 0, 32'h7000_0000, -32'sh1_0000,
			-32'sh1_0000, 32'h7fff_ffff, 32'h1_0000, 32'h1_0000}, 1'b0, '0);
		add_row('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 1'b0, '0);
		add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].res);
		for (int ph = 0; ph <= 4; ph++) begin
			if (ph > 0) drain_and_write(phase_thr[ph-1]);
			for (int n = 0; n < N_PER_PHASE; n++) begin
				if (n % 70 == 0) idle_on = ($urandom_range(0, 3) != 0);
				send_ray(random_ray(), 1'b0, '0);
			end
			idle_on = 1'b1;
			if (ph == 1) begin
				// zero threshold against directions at the edge of the threshold range
				send_ray(pack_ray('{0, 0, 0, 32'hffff, 32'hffff_0001, 32'h1_0000,
					-32'sh1_0000, -32'sh1_0000, -32'sh1_0000,
					32'h1_0000, 32'h1_0000, 32'h1_0000}), 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;
		while (hit_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/rbsi_pkg.sv
rtl/core/rbsi_div.sv
rtl/core/rbsi_delay.sv
rtl/core/ray_box_slab_intersect_top.sv
tb/tb_top.sv
